// ===== rtl/core/asft_pkg.sv =====
// shared types, constants and microcode table for the squelch floor tracker
package asft_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned FREQ_W      = 33;
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned WEIGHT_FRAC = 16;
  localparam int unsigned MARGIN_FRAC = 8;
  localparam int unsigned PROD_W      = DATA_W + CFG_W;
  localparam int unsigned STEP_W      = 3;

  localparam logic [CFG_W-1:0]  SETTLE_RESET  = 16'd500;
  localparam logic [CFG_W-1:0]  WEIGHT_RESET  = 16'd655;
  localparam logic [CFG_W-1:0]  MARGIN_RESET  = 16'd768;
  localparam logic [DATA_W-1:0] MINIMUM_RESET = 32'd8192;

  localparam logic CMD_FRAME   = 1'b0;
  localparam logic CMD_RELEARN = 1'b1;

  typedef enum logic [1:0] {
    REG_SETTLE  = 2'd0,
    REG_WEIGHT  = 2'd1,
    REG_MARGIN  = 2'd2,
    REG_MINIMUM = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    OP_NOP     = 3'd0,
    OP_FREQ    = 3'd1,
    OP_SETTLE  = 3'd2,
    OP_FLOOR   = 3'd3,
    OP_AVG_MUL = 3'd4,
    OP_AVG_ADD = 3'd5,
    OP_THR_MUL = 3'd6,
    OP_EMIT    = 3'd7
  } dp_op_t;

  typedef enum logic [1:0] {
    BR_NEXT   = 2'd0,
    BR_NO_AVG = 2'd1,
    BR_END    = 2'd2
  } br_t;

  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    dp_op_t op;
    br_t    br;
    step_t  target;
  } ucode_word_t;

  typedef struct packed {
    logic   load;
    dp_op_t op;
  } dp_ctrl_t;

  typedef struct packed {
    logic no_avg;
    logic out_hold;
  } dp_status_t;

  typedef struct packed {
    logic [CFG_W-1:0]  settle;
    logic [CFG_W-1:0]  weight;
    logic [CFG_W-1:0]  margin;
    logic [DATA_W-1:0] minimum;
  } cfg_t;

  localparam step_t STEP_THR = 3'd5;

  // program: frequency check, settle check, floor choice, average, threshold, emit
  function automatic ucode_word_t ucode_rom(step_t s);
    ucode_word_t w;
    w = '{op: OP_NOP, br: BR_END, target: '0};
    unique case (s)
      3'd0:    w = '{op: OP_FREQ,    br: BR_NEXT,   target: '0};
      3'd1:    w = '{op: OP_SETTLE,  br: BR_NEXT,   target: '0};
      3'd2:    w = '{op: OP_FLOOR,   br: BR_NO_AVG, target: STEP_THR};
      3'd3:    w = '{op: OP_AVG_MUL, br: BR_NEXT,   target: '0};
      3'd4:    w = '{op: OP_AVG_ADD, br: BR_NEXT,   target: '0};
      3'd5:    w = '{op: OP_THR_MUL, br: BR_NEXT,   target: '0};
      3'd6:    w = '{op: OP_EMIT,    br: BR_END,    target: '0};
      default: w = '{op: OP_NOP,     br: BR_END,    target: '0};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/asft_seq.sv =====
// microcode sequencer: step counter, control rom and branch logic
module asft_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  asft_pkg::dp_status_t  status,
  output asft_pkg::dp_ctrl_t    ctrl
);

  logic                 busy;
  asft_pkg::step_t      step;
  asft_pkg::ucode_word_t word;
  logic                 load;
  logic                 exec;

  assign word = asft_pkg::ucode_rom(step);
  assign load = in_valid && !busy;
  // the final step waits until the output register can take the result
  assign exec = busy && !((word.br == asft_pkg::BR_END) && status.out_hold);

  assign in_stall  = busy;
  assign ctrl.load = load;
  assign ctrl.op   = exec ? word.op : asft_pkg::OP_NOP;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (load) begin
      busy <= 1'b1;
      step <= '0;
    end else if (exec) begin
      unique case (word.br)
        asft_pkg::BR_NEXT: begin
          step <= step + 1'b1;
        end
        asft_pkg::BR_NO_AVG: begin
          step <= status.no_avg ? word.target : step + 1'b1;
        end
        default: begin
          busy <= 1'b0;
          step <= '0;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/asft_dp.sv =====
// datapath: tracker state, shared multiplier and result register
module asft_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  asft_pkg::dp_ctrl_t               ctrl,
  output asft_pkg::dp_status_t             status,
  input  asft_pkg::cfg_t                   cfg,
  input  logic                             cmd,
  input  logic [asft_pkg::DATA_W-1:0]      ratio,
  input  logic [asft_pkg::FREQ_W-1:0]      vfo_hz,
  input  logic                             learn_permit,
  input  logic [asft_pkg::DATA_W-1:0]      now_ms,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [asft_pkg::DATA_W-1:0]      threshold,
  output logic [asft_pkg::DATA_W-1:0]      floor_out,
  output logic                             learn_used
);

  localparam int unsigned DW = asft_pkg::DATA_W;
  localparam int unsigned FW = asft_pkg::FREQ_W;
  localparam int unsigned PW = asft_pkg::PROD_W;

  // latched request
  logic          cmd_q;
  logic [DW-1:0] ratio_q;
  logic [FW-1:0] vfo_q;
  logic          allow_q;
  logic [DW-1:0] now_q;

  // tracker state
  logic [DW-1:0] noise_floor;
  logic [FW-1:0] learned_freq;
  logic [DW-1:0] relearn_time;

  // working registers
  logic          learn;
  logic [DW-1:0] opa;
  logic [PW-1:0] prod;

  logic [FW:0]               fdiff;
  logic                      moved;
  logic [DW-1:0]             elapsed;
  logic                      floor_zero;
  logic                      ratio_low;
  logic [DW-1:0]             mul_a;
  logic [asft_pkg::CFG_W-1:0] mul_b;
  logic [PW-asft_pkg::MARGIN_FRAC-1:0] thr_shift;
  logic [DW-1:0]             thr_sat;
  logic [DW-1:0]             thr_val;
  logic                      emit;

  // 34-bit difference so a wrap never looks like a small move
  assign fdiff = {1'b0, vfo_q} - {1'b0, learned_freq};
  assign moved = !((fdiff == '0) || (fdiff == {{FW{1'b0}}, 1'b1}) || (fdiff == '1));

  assign elapsed    = now_q - relearn_time;
  assign floor_zero = (noise_floor == '0);
  assign ratio_low  = (ratio_q < noise_floor);

  assign status.no_avg   = floor_zero || ratio_low || !learn;
  assign status.out_hold = out_valid && out_stall;

  // one multiplier shared by the average step and the threshold
  always_comb begin
    if (ctrl.op == asft_pkg::OP_AVG_MUL) begin
      mul_a = opa;
      mul_b = cfg.weight;
    end else begin
      mul_a = noise_floor;
      mul_b = cfg.margin;
    end
  end

  assign thr_shift = prod[PW-1:asft_pkg::MARGIN_FRAC];
  assign thr_sat   = (|thr_shift[PW-asft_pkg::MARGIN_FRAC-1:DW]) ? '1 : thr_shift[DW-1:0];
  always_comb begin
    if (floor_zero) begin
      thr_val = '0;
    end else if (thr_sat < cfg.minimum) begin
      thr_val = cfg.minimum;
    end else begin
      thr_val = thr_sat;
    end
  end

  assign emit = (ctrl.op == asft_pkg::OP_EMIT);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_q   <= cmd;
      ratio_q <= ratio;
      vfo_q   <= vfo_hz;
      allow_q <= learn_permit;
      now_q   <= now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_floor  <= '0;
      learned_freq <= '0;
      relearn_time <= '0;
    end else begin
      unique case (ctrl.op)
        asft_pkg::OP_FREQ: begin
          if (cmd_q == asft_pkg::CMD_RELEARN) begin
            noise_floor  <= '0;
            relearn_time <= now_q;
          end else if (moved) begin
            noise_floor  <= '0;
            learned_freq <= vfo_q;
            relearn_time <= now_q;
          end
        end
        asft_pkg::OP_FLOOR: begin
          if (floor_zero) begin
            if (learn) begin
              noise_floor <= ratio_q;
            end
          end else if (ratio_low) begin
            noise_floor <= ratio_q;
          end
        end
        asft_pkg::OP_AVG_ADD: begin
          noise_floor <= noise_floor + prod[PW-1:asft_pkg::WEIGHT_FRAC];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      asft_pkg::OP_SETTLE: begin
        learn <= allow_q && (cmd_q != asft_pkg::CMD_RELEARN)
                 && !(elapsed < {{(DW-asft_pkg::CFG_W){1'b0}}, cfg.settle});
      end
      asft_pkg::OP_FLOOR: begin
        opa <= ratio_q - noise_floor;
      end
      asft_pkg::OP_AVG_MUL, asft_pkg::OP_THR_MUL: begin
        prod <= mul_a * mul_b;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      threshold  <= thr_val;
      floor_out  <= noise_floor;
      learn_used <= learn;
    end
  end

endmodule

// ===== rtl/core/adaptive_squelch_floor_tracker.sv =====
// top level of the adaptive squelch floor tracker: config registers and core
//
// Input channel (in_valid / in_stall) takes one request per frame: cmd selects
// a frame update or a relearn; ratio, vfo_hz, learn_permit and now_ms go with it.
// Output channel (out_valid / out_stall) returns one result per request:
// threshold, floor_out and learn_used.
// A request runs through a seven-step microcode program on one datapath with a
// single 32x16 multiplier; the two averaging steps are skipped when no average
// is taken. in_stall stays high while the program runs, so a new request is
// accepted only after the previous program has ended. The result sits in an
// output register; a new request is accepted while it waits. If the receiver
// still stalls when the next result is ready, the program holds on its last
// step until the register frees up. Reset clears the noise floor, learned
// frequency and relearn time to zero and loads the register defaults (settle
// 500 ms, weight 655, margin 768, minimum 8192). Registers are written over the
// APB port while the block is idle; the user must ensure it, it is not enforced.
module adaptive_squelch_floor_tracker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [3:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             cmd,
  input  logic [asft_pkg::DATA_W-1:0]      ratio,
  input  logic [asft_pkg::FREQ_W-1:0]      vfo_hz,
  input  logic                             learn_permit,
  input  logic [asft_pkg::DATA_W-1:0]      now_ms,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [asft_pkg::DATA_W-1:0]      threshold,
  output logic [asft_pkg::DATA_W-1:0]      floor_out,
  output logic                             learn_used
);

  asft_pkg::cfg_t       cfg;
  asft_pkg::dp_ctrl_t   ctrl;
  asft_pkg::dp_status_t status;
  asft_pkg::reg_idx_t   reg_idx;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = asft_pkg::reg_idx_t'(paddr[3:2]);
  // byte lane bits are ignored
  assign wr_en   = psel && penable && pwrite && pready && (paddr[1:0] == paddr[1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.settle  <= asft_pkg::SETTLE_RESET;
      cfg.weight  <= asft_pkg::WEIGHT_RESET;
      cfg.margin  <= asft_pkg::MARGIN_RESET;
      cfg.minimum <= asft_pkg::MINIMUM_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        asft_pkg::REG_SETTLE:  cfg.settle  <= pwdata[asft_pkg::CFG_W-1:0];
        asft_pkg::REG_WEIGHT:  cfg.weight  <= pwdata[asft_pkg::CFG_W-1:0];
        asft_pkg::REG_MARGIN:  cfg.margin  <= pwdata[asft_pkg::CFG_W-1:0];
        asft_pkg::REG_MINIMUM: cfg.minimum <= pwdata[asft_pkg::DATA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      asft_pkg::REG_SETTLE:  prdata = {16'b0, cfg.settle};
      asft_pkg::REG_WEIGHT:  prdata = {16'b0, cfg.weight};
      asft_pkg::REG_MARGIN:  prdata = {16'b0, cfg.margin};
      asft_pkg::REG_MINIMUM: prdata = cfg.minimum;
      default:               prdata = '0;
    endcase
  end

  asft_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .ctrl     (ctrl)
  );

  asft_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .status       (status),
    .cfg          (cfg),
    .cmd          (cmd),
    .ratio        (ratio),
    .vfo_hz       (vfo_hz),
    .learn_permit (learn_permit),
    .now_ms       (now_ms),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .threshold    (threshold),
    .floor_out    (floor_out),
    .learn_used   (learn_used)
  );

endmodule
